// ===== design/sclc_pkg.sv =====
// Shared types and constants for the size class live counter.
`default_nettype none

package sclc_pkg;

   // Field widths fixed by the item formats.
   localparam int SizeWidth   = 48;
   localparam int CountWidth  = 32;
   localparam int StatusWidth = 3;
   localparam int SlotWidth   = 4;
   localparam int UsedWidth   = 5;

   localparam logic [CountWidth-1:0] CountMax = '1;

   // Result status codes.
   typedef enum logic [StatusWidth-1:0] {
      ST_IGNORED   = 3'd0,
      ST_COUNTED   = 3'd1,
      ST_INSERTED  = 3'd2,
      ST_DROPPED   = 3'd3,
      ST_FREED     = 3'd4,
      ST_UNTRACKED = 3'd5
   } status_type;

   // Event kinds.
   typedef enum logic {
      CMD_ALLOCATE = 1'b0,
      CMD_FREE     = 1'b1
   } cmd_type;

   // One table entry as held in the entry memory.
   typedef struct packed {
      logic [SizeWidth-1:0]  size;
      logic [CountWidth-1:0] count;
   } entry_type;

endpackage : sclc_pkg

`default_nettype wire

// ===== design/size_class_live_counter.sv =====
// Top level of the size class live counter: entry memory, scan sequencer and result register.
`default_nettype none

//  Channel | Direction | Handshake             | Contents
//  req     | in        | req_tvalid/req_tready | tuser: cmd; tdata: size
//  rsp     | out       | rsp_tvalid/rsp_tready | tuser: status; tdata: slot, counts, entries
//  csr     | in        | csr_valid/csr_ready   | csr_data: tracking enable
//
// An item whose lookup reads k used entries (k at least one, at most TABLE_SLOTS) passes
// through a first read of the entry memory (S_FETCH), a compare of each entry in turn
// (S_CHECK) and a load of the output register (S_HOLD). An ignored item, or one that finds
// the table empty, goes straight to the load of the output register. The input is ready again
// once the result is loaded, so a new item is not accepted while one is still in flight.
// Reset clears the entry count, the untracked counter, the enable and all handshakes; the
// entry memory itself is not cleared since only written entries are ever read.
// A stalled result holds in the output register; the next item may be accepted meanwhile
// and its result then waits until the output register frees up.

module size_class_live_counter #(
   parameter int TABLE_SLOTS = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // Input items.
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [0:0]  req_tuser,   // [0] cmd
   input  wire logic [47:0] req_tdata,   // [47:0] size
   // Result items.
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [2:0]       rsp_tuser,   // [2:0] status
   output logic [79:0]      rsp_tdata,   // [3:0] slot_index, [35:4] slot_count,
                                         // [67:36] untracked_total, [72:68] entries_used,
                                         // [79:73] zero
   // Configuration.
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic        csr_data
);

   import sclc_pkg::*;

   localparam int IdxWidth = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
   localparam int CntWidth = $clog2(TABLE_SLOTS + 1);

   typedef enum logic [1:0] {
      S_IDLE,
      S_FETCH,
      S_CHECK,
      S_HOLD
   } state_type;

   // Entry memory.
   entry_type mem [TABLE_SLOTS];
   entry_type rd_ff;
   logic                wr_en;
   logic [IdxWidth-1:0] wr_addr;
   entry_type           wr_data;

   // Control state.
   state_type             state_ff, state_in;
   logic                  enable_ff, enable_in;
   logic [CntWidth-1:0]   used_ff, used_in;
   logic [CountWidth-1:0] untracked_ff, untracked_in;
   logic [IdxWidth-1:0]   scan_ff, scan_in;
   logic [IdxWidth-1:0]   chk_ff, chk_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   // Item being worked on.
   cmd_type              cmd_ff, cmd_in;
   logic [SizeWidth-1:0] size_ff, size_in;

   // Pending result.
   status_type            res_status_ff, res_status_in;
   logic [IdxWidth-1:0]   res_slot_ff, res_slot_in;
   logic [CountWidth-1:0] res_count_ff, res_count_in;
   logic [CountWidth-1:0] res_untracked_ff, res_untracked_in;
   logic [CntWidth-1:0]   res_used_ff, res_used_in;

   // Output register.
   logic [StatusWidth-1:0] rsp_status_ff, rsp_status_in;
   logic [SlotWidth-1:0]   rsp_slot_ff, rsp_slot_in;
   logic [CountWidth-1:0]  rsp_count_ff, rsp_count_in;
   logic [CountWidth-1:0]  rsp_untracked_ff, rsp_untracked_in;
   logic [UsedWidth-1:0]   rsp_used_ff, rsp_used_in;

   logic                  req_fire;
   cmd_type               cur_cmd;
   logic [SizeWidth-1:0]  cur_size;
   logic                  hit;
   logic                  last;
   logic                  full;
   logic                  do_miss;
   logic [31:0]           slot_wide;
   logic [31:0]           used_wide;

   assign req_tready = (state_ff == S_IDLE);
   assign csr_ready  = 1'b1;
   assign req_fire   = req_tvalid && req_tready;

   // The item in flight, taken straight from the port in the accepting cycle.
   assign cur_cmd  = (state_ff == S_IDLE) ? cmd_type'(req_tuser[0]) : cmd_ff;
   assign cur_size = (state_ff == S_IDLE) ? req_tdata : size_ff;

   // A hit needs a matching size, and for a free also a nonzero count.
   assign hit  = (rd_ff.size == size_ff) && ((cmd_ff == CMD_ALLOCATE) || (rd_ff.count != '0));
   assign last = (CntWidth'(chk_ff) + CntWidth'(1)) == used_ff;
   assign full = (used_ff == CntWidth'(TABLE_SLOTS));

   // Sequencer and read-modify-write of the scanned entry.
   always_comb begin
      state_in         = state_ff;
      enable_in        = enable_ff;
      used_in          = used_ff;
      untracked_in     = untracked_ff;
      scan_in          = scan_ff;
      chk_in           = chk_ff;
      cmd_in           = cmd_ff;
      size_in          = size_ff;
      res_status_in    = res_status_ff;
      res_slot_in      = res_slot_ff;
      res_count_in     = res_count_ff;
      res_untracked_in = res_untracked_ff;
      res_used_in      = res_used_ff;
      rsp_valid_in     = rsp_valid_ff;
      rsp_status_in    = rsp_status_ff;
      rsp_slot_in      = rsp_slot_ff;
      rsp_count_in     = rsp_count_ff;
      rsp_untracked_in = rsp_untracked_ff;
      rsp_used_in      = rsp_used_ff;
      wr_en            = 1'b0;
      wr_addr          = chk_ff;
      wr_data          = rd_ff;
      do_miss          = 1'b0;
      slot_wide        = 32'(res_slot_ff);
      used_wide        = 32'(res_used_ff);

      if (csr_valid && csr_ready) begin
         enable_in = csr_data;
      end

      // The taken result leaves the output register.
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               cmd_in  = cur_cmd;
               size_in = cur_size;
               if (!enable_ff) begin
                  res_status_in    = ST_IGNORED;
                  res_slot_in      = '0;
                  res_count_in     = '0;
                  res_untracked_in = untracked_ff;
                  res_used_in      = used_ff;
                  state_in         = S_HOLD;
               end else if (used_ff == '0) begin
                  do_miss = 1'b1;
               end else begin
                  scan_in  = '0;
                  state_in = S_FETCH;
               end
            end
         end
         S_FETCH: begin
            // Entry zero is read at this edge.
            chk_in   = scan_ff;
            scan_in  = scan_ff + IdxWidth'(1);
            state_in = S_CHECK;
         end
         S_CHECK: begin
            if (hit) begin
               wr_en   = 1'b1;
               wr_addr = chk_ff;
               wr_data = rd_ff;
               if (cmd_ff == CMD_ALLOCATE) begin
                  if (rd_ff.count != CountMax) begin
                     wr_data.count = rd_ff.count + CountWidth'(1);
                  end
                  res_status_in = ST_COUNTED;
               end else begin
                  wr_data.count = rd_ff.count - CountWidth'(1);
                  res_status_in = ST_FREED;
               end
               res_slot_in      = chk_ff;
               res_count_in     = wr_data.count;
               res_untracked_in = untracked_ff;
               res_used_in      = used_ff;
               state_in         = S_HOLD;
            end else if (last) begin
               do_miss = 1'b1;
            end else begin
               chk_in  = scan_ff;
               scan_in = scan_ff + IdxWidth'(1);
            end
         end
         S_HOLD: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in     = 1'b1;
               rsp_status_in    = res_status_ff;
               rsp_slot_in      = slot_wide[SlotWidth-1:0];
               rsp_count_in     = res_count_ff;
               rsp_untracked_in = res_untracked_ff;
               rsp_used_in      = used_wide[UsedWidth-1:0];
               state_in         = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // No used entry matched: append, drop or count an untracked free.
      if (do_miss) begin
         res_untracked_in = untracked_ff;
         res_used_in      = used_ff;
         res_slot_in      = '0;
         res_count_in     = '0;
         if (cur_cmd == CMD_ALLOCATE) begin
            if (!full) begin
               wr_en         = 1'b1;
               wr_addr       = used_ff[IdxWidth-1:0];
               wr_data.size  = cur_size;
               wr_data.count = CountWidth'(1);
               used_in       = used_ff + CntWidth'(1);
               res_status_in = ST_INSERTED;
               res_slot_in   = used_ff[IdxWidth-1:0];
               res_count_in  = CountWidth'(1);
               res_used_in   = used_ff + CntWidth'(1);
            end else begin
               res_status_in = ST_DROPPED;
            end
         end else begin
            if (untracked_ff != CountMax) begin
               untracked_in     = untracked_ff + CountWidth'(1);
               res_untracked_in = untracked_ff + CountWidth'(1);
            end
            res_status_in = ST_UNTRACKED;
         end
         state_in = S_HOLD;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         enable_ff    <= 1'b0;
         used_ff      <= '0;
         untracked_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         enable_ff    <= enable_in;
         used_ff      <= used_in;
         untracked_ff <= untracked_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      scan_ff          <= scan_in;
      chk_ff           <= chk_in;
      cmd_ff           <= cmd_in;
      size_ff          <= size_in;
      res_status_ff    <= res_status_in;
      res_slot_ff      <= res_slot_in;
      res_count_ff     <= res_count_in;
      res_untracked_ff <= res_untracked_in;
      res_used_ff      <= res_used_in;
      rsp_status_ff    <= rsp_status_in;
      rsp_slot_ff      <= rsp_slot_in;
      rsp_count_ff     <= rsp_count_in;
      rsp_untracked_ff <= rsp_untracked_in;
      rsp_used_ff      <= rsp_used_in;
   end

   // Entry memory: one write port, one registered read port at the scan address.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_ff <= mem[scan_ff];
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {7'b0, rsp_used_ff, rsp_untracked_ff, rsp_count_ff, rsp_slot_ff};

endmodule : size_class_live_counter

`default_nettype wire
